FILE: rtl/u16u8_pkg.sv
package u16u8_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] ONE_MAX    = 21'h00007F;
  localparam logic [20:0] TWO_MAX    = 21'h0007FF;
  localparam logic [20:0] THREE_MAX  = 21'h00FFFF;
  localparam logic [7:0]  LEAD4      = 8'hF0;
  localparam logic [7:0]  LEAD3      = 8'hE0;
  localparam logic [7:0]  LEAD2      = 8'hC0;
  localparam logic [7:0]  CONT       = 8'h80;
  localparam logic [2:0]  REPL_LEN   = 3'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } out_item_t;

  // One unit of work for the back end: optional U+FFFD, then optional code point.
  typedef struct packed {
    logic        prefix;
    logic        has_main;
    logic [20:0] cp;
    logic        last;
  } job_t;

  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= ONE_MAX) begin
      len = 3'd1;
    end else if (cp <= TWO_MAX) begin
      len = 3'd2;
    end else if (cp <= THREE_MAX) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] k);
    logic [2:0] len;
    logic [7:0] b;
    len = enc_len(cp);
    b = cp[7:0];
    unique case (len)
      3'd1: b = cp[7:0];
      3'd2: begin
        if (k == 2'd0) b = LEAD2 | {3'b000, cp[10:6]};
        else           b = CONT  | {2'b00, cp[5:0]};
      end
      3'd3: begin
        if (k == 2'd0)      b = LEAD3 | {4'b0000, cp[15:12]};
        else if (k == 2'd1) b = CONT  | {2'b00, cp[11:6]};
        else                b = CONT  | {2'b00, cp[5:0]};
      end
      default: begin
        unique case (k)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = CONT  | {2'b00, cp[17:12]};
          2'd2:    b = CONT  | {2'b00, cp[11:6]};
          default: b = CONT  | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/u16u8_front.sv
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  u16u8_pkg::in_item_t item,
  output logic                push,
  output u16u8_pkg::job_t     job
);

  logic       high_pending;
  logic [9:0] held_high_bits;
  logic       high_pending_next;
  logic       is_high;
  logic       is_low;

  assign is_high = (item.code_unit >= u16u8_pkg::HIGH_FIRST) &&
                   (item.code_unit <= u16u8_pkg::HIGH_LAST);
  assign is_low  = (item.code_unit >= u16u8_pkg::LOW_FIRST) &&
                   (item.code_unit <= u16u8_pkg::LOW_LAST);

  always_comb begin
    job.prefix        = 1'b0;
    job.has_main      = 1'b1;
    job.cp            = {5'b00000, item.code_unit};
    job.last          = item.last_unit;
    high_pending_next = 1'b0;
    if (high_pending && is_low) begin
      job.cp = u16u8_pkg::SUPP_BASE + 21'({held_high_bits, item.code_unit[9:0]});
    end else begin
      job.prefix = high_pending;
      if (is_high) begin
        if (item.last_unit) begin
          job.cp = u16u8_pkg::REPL_CP;
        end else begin
          job.has_main      = 1'b0;
          high_pending_next = 1'b1;
        end
      end else if (is_low) begin
        job.cp = u16u8_pkg::REPL_CP;
      end
    end
  end

  // Drop the job when a high surrogate is only being held.
  assign push = accept && (job.prefix || job.has_main);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
    end else if (accept) begin
      high_pending <= high_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
    end else if (accept && high_pending_next) begin
      held_high_bits <= item.code_unit[9:0];
    end
  end

endmodule

FILE: rtl/u16u8_queue.sv
module u16u8_queue #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u16u8_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u16u8_pkg::job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/u16u8_back.sv
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  u16u8_pkg::job_t      head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_item_t out_data
);

  u16u8_pkg::job_t cur;
  logic            cur_valid;
  logic [2:0]      idx;
  logic [2:0]      main_len;
  logic [2:0]      total;
  logic [2:0]      main_idx;
  logic            in_prefix;
  logic            at_end;
  logic            emit;
  logic            load;
  logic [7:0]      byte_sel;

  assign main_len  = cur.has_main ? u16u8_pkg::enc_len(cur.cp) : 3'd0;
  assign total     = (cur.prefix ? u16u8_pkg::REPL_LEN : 3'd0) + main_len;
  assign in_prefix = cur.prefix && (idx < u16u8_pkg::REPL_LEN);
  assign main_idx  = idx - (cur.prefix ? u16u8_pkg::REPL_LEN : 3'd0);
  assign at_end    = (idx == total - 3'd1);
  assign byte_sel  = in_prefix ? u16u8_pkg::enc_byte(u16u8_pkg::REPL_CP, idx[1:0])
                               : u16u8_pkg::enc_byte(cur.cp, main_idx[1:0]);

  assign emit = cur_valid && (!out_valid || !out_stall);
  assign load = !cur_valid || (emit && at_end);
  assign pop  = load && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= head_valid;
      idx       <= '0;
    end else if (emit) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte    <= byte_sel;
      out_data.run_last    <= at_end;
      out_data.string_last <= at_end && cur.last;
    end
  end

endmodule

FILE: rtl/utf16le_to_utf8_transcoder_core.sv
// UTF-16 to UTF-8 transcoder.
// Input channel (in_valid/in_stall/in_data): one UTF-16 code unit per transfer,
// with last_unit marking the final unit of a string. Output channel
// (out_valid/out_stall/out_data): one UTF-8 byte per transfer; run_last flags the
// final byte caused by an input unit, string_last the final byte of the string.
// A high surrogate that is not last produces no bytes until the next unit.
// Path: with the back end idle, the first byte of a unit reaches out_data through
// the back-end job register and then the output register; the queue entry itself
// is written at the transfer edge.
// Throughput: the output side moves one byte per cycle while out_stall is low, and
// a unit yields 1 to 4 bytes in normal text and up to 6 after a broken pair;
// the input side takes a unit per cycle while the job queue has room.
// Reset (rst, synchronous) empties the queue, drops any held high surrogate and
// clears out_valid. A stalled output holds its byte; the back end then stops,
// the queue fills, and in_stall rises once it is full.
module utf16le_to_utf8_transcoder_core #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u16u8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_item_t out_data
);

  logic            accept;
  logic            push;
  u16u8_pkg::job_t push_job;
  logic            full;
  logic            pop;
  logic            head_valid;
  u16u8_pkg::job_t head_job;

  // Hold the input whenever the job queue cannot take another entry.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Front: classify the unit and track the held high surrogate.
  u16u8_front front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .job    (push_job)
  );

  // Short queue decoupling classification from byte serialization.
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: advance through the bytes of each job, one per transfer.
  u16u8_back back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/u16u8_checker.sv
module u16u8_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input u16u8_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input u16u8_pkg::out_item_t out_data
);

  // Stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Stalled input unit holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  a_string_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.string_last |-> out_data.run_last)
    else $error("string_last outside run end");

  // A run always ends on a complete sequence: never on a lead byte.
  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.run_last |-> out_data.out_byte[7:6] != 2'b11)
    else $error("run ends on a lead byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf16le_to_utf8_transcoder_core u16u8_checker checker_inst (.*);
